// ----- hw/rtl/jsu_pkg.sv -----
// Package with the shared types, codes and the hex_value helper function of the JSON string decoder.
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_HEX2 = 3'd4,
        MODE_HEX3 = 3'd5,
        MODE_HEX4 = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        KIND_BYTE     = 3'd0,
        KIND_CLOSE    = 3'd1,
        KIND_BADSTART = 3'd2,
        KIND_BADHEX   = 3'd3,
        KIND_UNTERM   = 3'd4,
        KIND_EMPTY    = 3'd5
    } kind_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] data;
    } step_result_t;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [4:0] HEX_INVALID    = 5'd16;

    // Returns the value of a hexadecimal digit, or HEX_INVALID for any other byte.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        if (b inside {[8'h30:8'h39]}) begin
            v = {1'b0, b[3:0]};
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = {1'b0, b[3:0] + 4'd9};
        end else begin
            v = HEX_INVALID;
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/jsu_step_logic.sv -----
// Combinational next-state and result logic for one text transaction.
module jsu_step_logic (
    input  jsu_pkg::mode_t        mode_in,
    input  logic [3:0]            nibble_in,
    input  logic [7:0]            text_byte,
    input  logic                  end_of_text,
    output jsu_pkg::mode_t        mode_out,
    output logic [3:0]            nibble_out,
    output jsu_pkg::step_result_t result
);
    import jsu_pkg::*;

    logic [4:0] digit;

    assign digit = hex_value(text_byte);

    always_comb begin
        mode_out     = mode_in;
        nibble_out   = nibble_in;
        result.valid = 1'b0;
        result.kind  = KIND_BYTE;
        result.data  = 8'h00;
        if (end_of_text) begin
            result.valid = 1'b1;
            if (mode_in == MODE_IDLE) begin
                result.kind = KIND_EMPTY;
            end else begin
                result.kind = KIND_UNTERM;
                mode_out    = MODE_IDLE;
                nibble_out  = 4'h0;
            end
        end else begin
            case (mode_in)
                MODE_STR: begin
                    if (text_byte == CHAR_BACKSLASH) begin
                        mode_out = MODE_ESC;
                    end else if (text_byte == CHAR_QUOTE) begin
                        mode_out     = MODE_IDLE;
                        result.valid = 1'b1;
                        result.kind  = KIND_CLOSE;
                    end else begin
                        result.valid = 1'b1;
                        result.data  = text_byte;
                    end
                end
                MODE_ESC: begin
                    mode_out     = MODE_STR;
                    result.valid = 1'b1;
                    case (text_byte)
                        CHAR_B:  result.data = 8'h08;
                        CHAR_F:  result.data = 8'h0C;
                        CHAR_N:  result.data = 8'h0A;
                        CHAR_R:  result.data = 8'h0D;
                        CHAR_T:  result.data = 8'h09;
                        CHAR_U: begin
                            mode_out     = MODE_HEX1;
                            result.valid = 1'b0;
                        end
                        default: result.data = text_byte;
                    endcase
                end
                MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
                    if (digit == HEX_INVALID) begin
                        mode_out     = MODE_IDLE;
                        nibble_out   = 4'h0;
                        result.valid = 1'b1;
                        result.kind  = KIND_BADHEX;
                    end else if (mode_in == MODE_HEX1 || mode_in == MODE_HEX3) begin
                        nibble_out = digit[3:0];
                        mode_out   = (mode_in == MODE_HEX1) ? MODE_HEX2 : MODE_HEX4;
                    end else begin
                        nibble_out   = 4'h0;
                        mode_out     = (mode_in == MODE_HEX2) ? MODE_HEX3 : MODE_STR;
                        result.valid = 1'b1;
                        result.data  = {nibble_in, digit[3:0]};
                    end
                end
                default: begin
                    mode_out = MODE_IDLE;
                    if (text_byte inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
                        mode_out = MODE_IDLE;
                    end else if (text_byte == CHAR_QUOTE) begin
                        mode_out = MODE_STR;
                    end else begin
                        result.valid = 1'b1;
                        result.kind  = KIND_BADSTART;
                    end
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/json_string_unescape.sv -----
// Top level of the streaming decoder for quoted JSON strings.
//
//  Channel | Direction | Transaction contents
//  s_      | in        | tdata: text byte; tuser: end-of-text flag
//  m_      | out       | tdata: decoded byte; tuser: result kind
//
// A text transaction is registered, decoded combinationally from the input
// register and its result, if any, lands in the output register.
// One text transaction is taken every cycle while m_ does not stall a result.
// aresetn is synchronous and active low; it empties both registers and
// returns the decoder to idle. A stall on m_ holds the output register, and
// only a transaction that would produce a result waits in the input register.
module json_string_unescape (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic [0:0] s_tuser,   // [0] end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] decoded_byte
    output logic [2:0] m_tuser    // [2:0] kind
);
    import jsu_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_end_reg;
    mode_t        mode_reg;
    mode_t        mode_next;
    logic [3:0]   nibble_reg;
    logic [3:0]   nibble_next;
    logic         out_valid_reg;
    kind_t        out_kind_reg;
    logic [7:0]   out_data_reg;
    step_result_t step_res;
    logic         advance;
    logic         out_free;

    jsu_step_logic u_step (
        .mode_in     (mode_reg),
        .nibble_in   (nibble_reg),
        .text_byte   (in_byte_reg),
        .end_of_text (in_end_reg),
        .mode_out    (mode_next),
        .nibble_out  (nibble_next),
        .result      (step_res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !step_res.valid);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            nibble_reg <= 4'h0;
        end else if (advance) begin
            mode_reg   <= mode_next;
            nibble_reg <= nibble_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && step_res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && step_res.valid) begin
            out_kind_reg <= step_res.kind;
            out_data_reg <= step_res.data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    a_data_zero_unless_byte : assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg != KIND_BYTE |-> out_data_reg == 8'h00)
        else $error("decoded byte not zero on a status result");

    a_end_returns_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_end_reg |=> mode_reg == MODE_IDLE)
        else $error("decoder not idle after end of text");

    a_nibble_clear : assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_HEX2 && mode_reg != MODE_HEX4 |-> nibble_reg == 4'h0)
        else $error("stale high nibble outside a hex pair");

    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !(advance && step_res.valid))
        else $error("result overwrote a stalled output");

endmodule
